/* src/dcbd_pkg.sv */
// Widths, constants and month table for the day count between dates unit.
package dcbd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 22;
  // Day number of the largest 14-bit year stays below 2^23.
  localparam int DN_W   = 23;
  localparam int MDAY_W = 9;
  localparam int Q_W    = 8;
  localparam int LEAP_W = 13;

  // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for all 14-bit y
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + 13;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [MDAY_W-1:0] mday_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  // Days of the months before month m; month 0 adds none, 13 and up add all twelve.
  function automatic mday_t days_before_month(input logic [MON_W-1:0] m);
    mday_t v;
    unique case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      4'd12:      v = 9'd334;
      default:    v = 9'd365;
    endcase
    return v;
  endfunction

endpackage

/* src/day_count_between_dates_unit.sv */
// Gregorian day count between two dates, four-stage pipeline.
//
// Usage:
//   Drive the two dates and count_end_day and raise start for one cycle.
//   The item is taken at the rising edge where start is high and busy is
//   low. busy stays low: the pipeline takes one date pair every cycle.
//   After the transfer the item passes the stage registers in order, and
//   day_count is on the port for exactly one cycle with done high; results
//   leave in the order items came in.
//   The pipeline takes one item per cycle. The stages are:
//   reciprocal multiply for the century quotient, leap and year-day terms,
//   day number sum, and difference with clamping.
//   day_count is 0 when the first date is not strictly earlier than the
//   second, clamped at 0 if the day numbers run the other way, and
//   saturated at the 22-bit maximum.
//   Reset (rst, synchronous, active high) clears the valid bits so no
//   stale result is flagged; the payload registers are not cleared.
//   The receiver cannot stall: each result must be taken in its cycle.
module day_count_between_dates_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dcbd_pkg::DAY_W-1:0]    start_day,
  input  logic [dcbd_pkg::MON_W-1:0]    start_month,
  input  logic [dcbd_pkg::YEAR_W-1:0]   start_year,
  input  logic [dcbd_pkg::DAY_W-1:0]    end_day,
  input  logic [dcbd_pkg::MON_W-1:0]    end_month,
  input  logic [dcbd_pkg::YEAR_W-1:0]   end_year,
  input  logic                          count_end_day,
  output logic                          done,
  output logic [dcbd_pkg::CNT_W-1:0]    day_count
);

  // Index 0 is the first date, index 1 the second.
  dcbd_pkg::date_t                      dt [2];

  // Stage 1 registers
  logic                                 v1;
  logic                                 earlier1;
  logic                                 inc1;
  logic [dcbd_pkg::YEAR_W-1:0]          y1 [2];
  logic [dcbd_pkg::Q_W-1:0]             q1 [2];
  logic [dcbd_pkg::DAY_W-1:0]           d1 [2];
  dcbd_pkg::mday_t                      md1 [2];
  logic                                 late1 [2];

  // Stage 2 registers
  logic                                 v2;
  logic                                 earlier2;
  logic                                 inc2;
  logic [dcbd_pkg::DN_W-1:0]            y365_2 [2];
  logic [dcbd_pkg::LEAP_W-1:0]          leaps2 [2];
  logic                                 ladd2 [2];
  logic [dcbd_pkg::DAY_W-1:0]           d2 [2];
  dcbd_pkg::mday_t                      md2 [2];

  // Stage 3 registers
  logic                                 v3;
  logic                                 earlier3;
  logic                                 inc3;
  logic [dcbd_pkg::DN_W-1:0]            dn3 [2];

  // Combinational signals
  logic                                 accept;
  logic                                 earlier_c;
  logic [dcbd_pkg::Q_W-1:0]             q_c [2];
  logic [dcbd_pkg::PROD_W-1:0]          prod_c [2];
  logic [dcbd_pkg::YEAR_W-1:0]          r_c [2];
  logic                                 rnz_c [2];
  logic                                 leap_c [2];
  logic [dcbd_pkg::LEAP_W-1:0]          leaps_c [2];
  logic [dcbd_pkg::DN_W-1:0]            dn_c [2];
  logic [dcbd_pkg::DN_W:0]              diff_c;
  logic [dcbd_pkg::CNT_W-1:0]           day_count_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign dt[0] = '{day: start_day, month: start_month, year: start_year};
  assign dt[1] = '{day: end_day,   month: end_month,   year: end_year};

  assign earlier_c = (start_year < end_year) ||
                     ((start_year == end_year) &&
                      ((start_month < end_month) ||
                       ((start_month == end_month) && (start_day < end_day))));

  // Stage 1: century quotient by reciprocal multiply, month lookup
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod_c[i] = dcbd_pkg::PROD_W'(dt[i].year) * dcbd_pkg::PROD_W'(dcbd_pkg::RECIP_100);
      q_c[i]    = prod_c[i][dcbd_pkg::RECIP_SHIFT +: dcbd_pkg::Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    earlier1 <= earlier_c;
    inc1     <= count_end_day;
    for (int i = 0; i < 2; i++) begin
      y1[i]    <= dt[i].year;
      q1[i]    <= q_c[i];
      d1[i]    <= dt[i].day;
      md1[i]   <= dcbd_pkg::days_before_month(dt[i].month);
      late1[i] <= (dt[i].month >= dcbd_pkg::MON_W'(3));
    end
  end

  // Stage 2: leap days in earlier years, leap flag, year days
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      r_c[i]    = y1[i] - (dcbd_pkg::YEAR_W'(q1[i]) * dcbd_pkg::YEAR_W'(100));
      rnz_c[i]  = (r_c[i] != '0);
      leap_c[i] = rnz_c[i] ? (y1[i][1:0] == 2'b00) : (q1[i][1:0] == 2'b00);
      // ceil(y/4) - ceil(y/100) + ceil(y/400); one extra bit keeps y+3 from wrapping
      leaps_c[i] = dcbd_pkg::LEAP_W'(((dcbd_pkg::YEAR_W + 1)'(y1[i])
                                      + (dcbd_pkg::YEAR_W + 1)'(3)) >> 2)
                 - dcbd_pkg::LEAP_W'(q1[i]) - dcbd_pkg::LEAP_W'(rnz_c[i])
                 + dcbd_pkg::LEAP_W'(q1[i] >> 2)
                 + dcbd_pkg::LEAP_W'(rnz_c[i] || (q1[i][1:0] != 2'b00));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    earlier2 <= earlier1;
    inc2     <= inc1;
    for (int i = 0; i < 2; i++) begin
      y365_2[i] <= dcbd_pkg::DN_W'(y1[i]) * dcbd_pkg::DN_W'(365);
      leaps2[i] <= leaps_c[i];
      ladd2[i]  <= late1[i] && leap_c[i];
      d2[i]     <= d1[i];
      md2[i]    <= md1[i];
    end
  end

  // Stage 3: day numbers
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dn_c[i] = y365_2[i] + dcbd_pkg::DN_W'(leaps2[i]) + dcbd_pkg::DN_W'(md2[i])
              + dcbd_pkg::DN_W'(d2[i]) + dcbd_pkg::DN_W'(ladd2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    earlier3 <= earlier2;
    inc3     <= inc2;
    for (int i = 0; i < 2; i++) begin
      dn3[i] <= dn_c[i];
    end
  end

  // Stage 4: difference, clamp at zero, saturate at the top
  always_comb begin
    diff_c = {1'b0, dn3[1]} - {1'b0, dn3[0]} + (dcbd_pkg::DN_W + 1)'(inc3);
    if (!earlier3 || diff_c[dcbd_pkg::DN_W]) begin
      day_count_next = '0;
    end else if (diff_c[dcbd_pkg::DN_W-1:dcbd_pkg::CNT_W] != '0) begin
      day_count_next = dcbd_pkg::CNT_MAX;
    end else begin
      day_count_next = diff_c[dcbd_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    day_count <= day_count_next;
  end

  // A result strobe only follows an earlier matching transfer.
  a_done_after_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("done without a matching transfer");

  // No result strobe in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done raised right after reset");

  // A pair whose first date is not earlier yields zero.
  a_zero_if_not_earlier: assert property (@(posedge clk) disable iff (rst)
    (v3 && !earlier3) |=> (done && (day_count == '0)))
    else $error("nonzero count for dates not in order");

  // Every stage-3 item reaches the output.
  a_stage_to_done: assert property (@(posedge clk) disable iff (rst)
    v3 |=> done)
    else $error("item dropped in last stage");

endmodule
